### rtl/sorted_block_sample_packer_unit_assert.svh
// ----------------------------------------------------------------------------
// sorted_block_sample_packer_unit_assert.svh
// assertion macros shared by the packer rtl files
// ----------------------------------------------------------------------------
`ifndef SORTED_BLOCK_SAMPLE_PACKER_UNIT_ASSERT_SVH
`define SORTED_BLOCK_SAMPLE_PACKER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define SBSP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sbsp assertion failed");
// condition must never be seen outside reset
`define SBSP_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("sbsp forbidden condition seen");
`else
`define SBSP_ASSERT(lbl, clk, rstn, prop)
`define SBSP_NEVER(lbl, clk, rstn, expr)
`endif

`endif

### rtl/sbsp_pkg.sv
// ----------------------------------------------------------------------------
// sbsp_pkg
// shared constants, types and helper functions of the sample packer
// ----------------------------------------------------------------------------
`default_nettype none

package sbsp_pkg;

  localparam int BLOCK_SIZE = 7;
  localparam int IDX_W      = 3;
  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 16;
  localparam int MSB_W      = 4;
  localparam int PERM_W     = 13;
  localparam int BYTE_W     = 8;
  localparam int NB_W       = 5;
  localparam int KEY_W      = MAG_W + SAMPLE_W + IDX_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_SIZE - 1);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [MAG_W-1:0]    mag_t;
  typedef logic [PERM_W-1:0]   perm_t;

  typedef struct packed {
    logic             wr_en;
    logic             start;
    logic [IDX_W-1:0] wr_idx;
    sample_t          wr_data;
  } rank_ctl_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    perm_t perm;
  } rank_sts_t;

  // magnitude of a two's complement sample, -32768 gives 32768
  function automatic mag_t mag_of(input sample_t raw);
    mag_t m;
    m = raw[SAMPLE_W-1] ? (mag_t'(~raw) + mag_t'(1)) : mag_t'(raw);
    return m;
  endfunction

  // index of the highest set bit, zero and one both give 0
  function automatic logic [MSB_W-1:0] msb_of(input mag_t mag);
    logic [MSB_W-1:0] r;
    r = '0;
    for (int k = 1; k < MAG_W; k++) begin
      if (mag[k]) r = MSB_W'(k);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/sorted_block_sample_packer_unit.sv
// ----------------------------------------------------------------------------
// sorted_block_sample_packer_unit
// collects seven samples, ranks them, then sends the lehmer number, the
// largest sample and the bit-packed remainder as a byte stream
// ----------------------------------------------------------------------------
//  channel | dir | tdata                     | tlast
//  in_     | in  | [15:0] sample             | -
//  out_    | out | [7:0]  code_byte         | block_end
//
//  the first six samples of a block are taken one a cycle
//  the seventh starts ranking: one comparator pass per rank, each a scan and a commit, then a done pulse
//  then two lehmer bytes, two raw bytes and up to 102 packed bits, one a cycle
//  in_tready is low from the seventh sample until the last word is loaded
//  a stalled out_tready holds the sequencer whenever the next word is due
//  synchronous active-low reset; the block restarts at sample position zero
`default_nettype none
`include "sorted_block_sample_packer_unit_assert.svh"

module sorted_block_sample_packer_unit (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [15:0] in_tdata,   // [15:0] sample
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,  // [7:0] code_byte
  output logic       out_tlast   // block_end
);

  localparam logic [2:0] S_FILL  = 3'd0;
  localparam logic [2:0] S_RANK  = 3'd1;
  localparam logic [2:0] S_PERM0 = 3'd2;
  localparam logic [2:0] S_PERM1 = 3'd3;
  localparam logic [2:0] S_RAW0  = 3'd4;
  localparam logic [2:0] S_RAW1  = 3'd5;
  localparam logic [2:0] S_PACK  = 3'd6;

  logic [2:0]                        state_r, state_nxt;
  logic [sbsp_pkg::IDX_W-1:0]        fill_r, fill_nxt;
  logic [sbsp_pkg::IDX_W-1:0]        samp_r, samp_nxt;
  logic [sbsp_pkg::NB_W-1:0]         nbits_r, nbits_nxt;
  logic [2:0]                        bitpos_r, bitpos_nxt;
  logic [sbsp_pkg::BYTE_W-1:0]       byte_r, byte_nxt;
  logic                              ovalid_r, ovalid_nxt;
  logic [sbsp_pkg::BYTE_W-1:0]       odata_r, odata_nxt;
  logic                              olast_r, olast_nxt;

  sbsp_pkg::rank_ctl_t               rank_ctl;
  sbsp_pkg::rank_sts_t               rank_sts;
  sbsp_pkg::sample_t                 cur_raw;
  sbsp_pkg::mag_t                    cur_mag;
  logic [sbsp_pkg::NB_W-1:0]         cur_nb;
  logic [sbsp_pkg::SAMPLE_W:0]       cur_sext;
  logic                              cur_bit;
  logic                              slot_free;
  logic                              in_acc;
  logic                              final_bit;
  logic [sbsp_pkg::BYTE_W-1:0]       byte_fill;

  assign in_tready = (state_r == S_FILL);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !ovalid_r || out_tready;

  assign rank_ctl.wr_en   = in_acc;
  assign rank_ctl.start   = in_acc && (fill_r == sbsp_pkg::LAST_IDX);
  assign rank_ctl.wr_idx  = fill_r;
  assign rank_ctl.wr_data = in_tdata;

  sbsp_rank u_rank (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (rank_ctl),
    .rd_idx  (samp_r),
    .rd_data (cur_raw),
    .sts     (rank_sts)
  );

  assign cur_mag  = sbsp_pkg::mag_of(cur_raw);
  // width of the next sample follows this one's magnitude
  assign cur_nb   = sbsp_pkg::NB_W'(sbsp_pkg::msb_of(cur_mag)) + sbsp_pkg::NB_W'(2);
  assign cur_sext = {cur_raw[sbsp_pkg::SAMPLE_W-1], cur_raw};
  assign cur_bit  = cur_sext[nbits_r - 1'b1];
  assign final_bit = (nbits_r == sbsp_pkg::NB_W'(1)) &&
                     ((samp_r == sbsp_pkg::LAST_IDX) || (cur_mag == '0));

  // msb-first fill of the current word, fresh word clears the padding
  always_comb begin
    byte_fill = (bitpos_r == 3'd0) ? '0 : byte_r;
    byte_fill[~bitpos_r] = cur_bit;
  end

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    samp_nxt   = samp_r;
    nbits_nxt  = nbits_r;
    bitpos_nxt = bitpos_r;
    byte_nxt   = byte_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    unique case (state_r)
      S_FILL: begin
        if (in_acc) begin
          if (fill_r == sbsp_pkg::LAST_IDX) begin
            fill_nxt  = '0;
            state_nxt = S_RANK;
          end else begin
            fill_nxt = fill_r + 1'b1;
          end
        end
      end
      S_RANK: begin
        if (rank_sts.done) begin
          samp_nxt  = '0;
          state_nxt = S_PERM0;
        end
      end
      S_PERM0: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = rank_sts.perm[7:0];
          olast_nxt  = 1'b0;
          state_nxt  = S_PERM1;
        end
      end
      S_PERM1: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = sbsp_pkg::BYTE_W'(rank_sts.perm >> sbsp_pkg::BYTE_W);
          olast_nxt  = 1'b0;
          state_nxt  = S_RAW0;
        end
      end
      S_RAW0: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = cur_raw[7:0];
          olast_nxt  = 1'b0;
          state_nxt  = S_RAW1;
        end
      end
      S_RAW1: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = cur_raw[15:8];
          olast_nxt  = (cur_mag == '0);
          nbits_nxt  = cur_nb;
          bitpos_nxt = 3'd0;
          samp_nxt   = samp_r + 1'b1;
          state_nxt  = (cur_mag == '0) ? S_FILL : S_PACK;
        end
      end
      S_PACK: begin
        if (slot_free || !((bitpos_r == 3'd7) || final_bit)) begin
          byte_nxt   = byte_fill;
          bitpos_nxt = bitpos_r + 1'b1;
          if ((bitpos_r == 3'd7) || final_bit) begin
            ovalid_nxt = 1'b1;
            odata_nxt  = byte_fill;
            olast_nxt  = final_bit;
          end
          if (nbits_r == sbsp_pkg::NB_W'(1)) begin
            nbits_nxt = cur_nb;
            if (final_bit) begin
              state_nxt = S_FILL;
            end else begin
              samp_nxt = samp_r + 1'b1;
            end
          end else begin
            nbits_nxt = nbits_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_FILL;
      fill_r   <= '0;
      samp_r   <= '0;
      nbits_r  <= '0;
      bitpos_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      samp_r   <= samp_nxt;
      nbits_r  <= nbits_nxt;
      bitpos_r <= bitpos_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  `SBSP_ASSERT(a_done_in_rank, clk, rst_n, rank_sts.done |-> (state_r == S_RANK))
  `SBSP_ASSERT(a_pack_has_bits, clk, rst_n, (state_r == S_PACK) |-> (nbits_r != '0))
  `SBSP_ASSERT(a_start_ranks, clk, rst_n, rank_ctl.start |=> (rank_sts.busy && (state_r == S_RANK)))

endmodule

`default_nettype wire

### rtl/sbsp_rank.sv
// ----------------------------------------------------------------------------
// sbsp_rank
// sample store and selection ranker: one key comparator scans the block once
// per rank, then a commit cycle updates the lehmer number and sorted copy
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_block_sample_packer_unit_assert.svh"

module sbsp_rank (
  input  wire                         clk,
  input  wire                         rst_n,
  input  sbsp_pkg::rank_ctl_t         ctl,
  input  wire [sbsp_pkg::IDX_W-1:0]   rd_idx,
  output sbsp_pkg::sample_t           rd_data,
  output sbsp_pkg::rank_sts_t         sts
);

  sbsp_pkg::sample_t                 store_r  [sbsp_pkg::BLOCK_SIZE];
  sbsp_pkg::sample_t                 sorted_r [sbsp_pkg::BLOCK_SIZE];

  logic                              busy_r, busy_nxt;
  logic                              commit_r, commit_nxt;
  logic                              done_r, done_nxt;
  logic                              have_r, have_nxt;
  logic [sbsp_pkg::IDX_W-1:0]        i_r, i_nxt;
  logic [sbsp_pkg::IDX_W-1:0]        j_r, j_nxt;
  logic [sbsp_pkg::BLOCK_SIZE-1:0]   taken_r, taken_nxt;
  logic [sbsp_pkg::KEY_W-1:0]        best_r, best_nxt;
  sbsp_pkg::perm_t                   perm_r, perm_nxt;

  sbsp_pkg::sample_t                 scan_raw;
  logic [sbsp_pkg::KEY_W-1:0]        scan_key;
  logic [sbsp_pkg::IDX_W-1:0]        win_idx;
  sbsp_pkg::sample_t                 win_raw;
  logic [sbsp_pkg::IDX_W-1:0]        free_below;
  logic [sbsp_pkg::IDX_W-1:0]        radix;
  sbsp_pkg::perm_t                   perm_sum;

  assign scan_raw = store_r[j_r];
  // key order: magnitude, then value (sign-flipped), then position
  assign scan_key = {sbsp_pkg::mag_of(scan_raw), scan_raw ^ 16'h8000, j_r};
  assign win_idx  = best_r[sbsp_pkg::IDX_W-1:0];
  assign win_raw  = best_r[sbsp_pkg::IDX_W +: sbsp_pkg::SAMPLE_W] ^ 16'h8000;
  assign radix    = sbsp_pkg::LAST_IDX - i_r;
  assign perm_sum = perm_r + sbsp_pkg::perm_t'(free_below);

  // free positions below the winner
  always_comb begin
    free_below = '0;
    for (int k = 0; k < sbsp_pkg::BLOCK_SIZE; k++) begin
      if (k < int'(win_idx) && !taken_r[k]) free_below = free_below + 1'b1;
    end
  end

  always_comb begin
    busy_nxt   = busy_r;
    commit_nxt = commit_r;
    done_nxt   = 1'b0;
    have_nxt   = have_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    taken_nxt  = taken_r;
    best_nxt   = best_r;
    perm_nxt   = perm_r;
    if (ctl.start) begin
      busy_nxt   = 1'b1;
      commit_nxt = 1'b0;
      have_nxt   = 1'b0;
      i_nxt      = '0;
      j_nxt      = '0;
      taken_nxt  = '0;
      perm_nxt   = '0;
    end else if (busy_r && !commit_r) begin
      if (!taken_r[j_r] && (!have_r || scan_key > best_r)) begin
        best_nxt = scan_key;
        have_nxt = 1'b1;
      end
      if (j_r == sbsp_pkg::LAST_IDX) begin
        commit_nxt = 1'b1;
      end else begin
        j_nxt = j_r + 1'b1;
      end
    end else if (busy_r) begin
      taken_nxt[win_idx] = 1'b1;
      if (i_r != sbsp_pkg::LAST_IDX) begin
        perm_nxt = sbsp_pkg::perm_t'(perm_sum * radix);
        i_nxt    = i_r + 1'b1;
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      commit_nxt = 1'b0;
      have_nxt   = 1'b0;
      j_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      commit_r <= 1'b0;
      done_r   <= 1'b0;
      have_r   <= 1'b0;
      i_r      <= '0;
      j_r      <= '0;
      taken_r  <= '0;
      perm_r   <= '0;
    end else begin
      busy_r   <= busy_nxt;
      commit_r <= commit_nxt;
      done_r   <= done_nxt;
      have_r   <= have_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      taken_r  <= taken_nxt;
      perm_r   <= perm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    if (ctl.wr_en) begin
      store_r[ctl.wr_idx] <= ctl.wr_data;
    end
    if (busy_r && commit_r) begin
      sorted_r[i_r] <= win_raw;
    end
  end

  assign rd_data   = sorted_r[rd_idx];
  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign sts.perm  = perm_r;

  `SBSP_ASSERT(a_commit_has_winner, clk, rst_n, (busy_r && commit_r) |-> have_r)
  `SBSP_ASSERT(a_taken_tracks_rank, clk, rst_n, busy_r |-> ($countones(taken_r) == int'(i_r)))
  `SBSP_NEVER(a_done_while_busy, clk, rst_n, done_r && busy_r)

endmodule

`default_nettype wire

### tb/sorted_block_sample_packer_unit_test.sv
// ----------------------------------------------------------------------------
// sorted_block_sample_packer_unit_test
// self-checking bench: streams blocks of seven samples into the packer and
// compares every output word with a behavioural encoder or with fixed bytes of the block
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_block_sample_packer_unit_test;

  localparam int BLK        = sbsp_pkg::BLOCK_SIZE;
  localparam int MAX_WORDS  = 17;
  localparam int STALL_MAX  = 2000;
  localparam int N_BLOCKS   = 41;
  localparam int CALM_TAIL  = 6;
  localparam int DIRECT_LEN = 21;

  typedef enum int {MODE_FULL, MODE_TINY, MODE_EXTREME, MODE_WIDTH, MODE_REPEAT} sample_mode_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       block_end;
  } out_word_t;

  // n_fixed words of fixed_bytes, first word in the low byte, replace the prediction
  typedef struct packed {
    logic [15:0] sample;
    logic [2:0]  n_fixed;
    logic [31:0] fixed_bytes;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [DIRECT_LEN] = '{
    // silent block after reset: lehmer 5039, largest zero ends the block
    '{16'h0000, 3'd0, 32'h0}, '{16'h0000, 3'd0, 32'h0}, '{16'h0000, 3'd0, 32'h0},
    '{16'h0000, 3'd0, 32'h0}, '{16'h0000, 3'd0, 32'h0}, '{16'h0000, 3'd0, 32'h0},
    '{16'h0000, 3'd4, 32'h0000_13af},
    // all most-negative: every later sample takes 17 bits, longest block
    '{16'h8000, 3'd0, 32'h0}, '{16'h8000, 3'd0, 32'h0}, '{16'h8000, 3'd0, 32'h0},
    '{16'h8000, 3'd0, 32'h0}, '{16'h8000, 3'd0, 32'h0}, '{16'h8000, 3'd0, 32'h0},
    '{16'h8000, 3'd0, 32'h0},
    // equal magnitudes of both signs, magnitude one, and a zero that stops packing
    '{16'h7fff, 3'd0, 32'h0}, '{16'h8001, 3'd0, 32'h0}, '{16'h8000, 3'd0, 32'h0},
    '{16'h0001, 3'd0, 32'h0}, '{16'hffff, 3'd0, 32'h0}, '{16'h0000, 3'd0, 32'h0},
    '{16'h5a5a, 3'd0, 32'h0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'h0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  out_word_t   expected_words [$];
  logic [15:0] held_samples [BLK];
  int          held_count = 0;
  logic [7:0]  block_bytes [MAX_WORDS];
  int          block_len;
  int          fail_count = 0;
  int          idle_level = 0;
  int          rep_value;
  int          quiet_cycles = 0;

  sorted_block_sample_packer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [16:0] magnitude(logic [15:0] raw);
    return raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
  endfunction

  // highest set bit, magnitudes zero and one both give 0
  function automatic int top_bit(logic [16:0] m);
    int r;
    r = 0;
    for (int k = 1; k < 16; k++) begin
      if (m[k]) r = k;
    end
    return r;
  endfunction

  // descending order on magnitude, then value, then position
  function automatic logic [63:0] rank_key(logic [15:0] raw, int idx);
    return {15'd0, magnitude(raw), raw ^ 16'h8000, 16'(idx)};
  endfunction

  // stores a sample; on the seventh, encodes the block into block_bytes
  function automatic bit encode_sample(logic [15:0] s);
    int          order [BLK];
    logic [6:0]  used;
    logic [6:0]  taken;
    int          best;
    logic [63:0] best_key;
    bit          have;
    int          p;
    int          cnt;
    logic [31:0] perm;
    logic [16:0] prev_mag;
    bit          stop;
    int          bitpos;
    int          nb;
    logic [31:0] v;
    logic [15:0] raw;

    if (held_count >= BLK) held_count = 0;
    held_samples[held_count] = s;
    held_count++;
    if (held_count < BLK) return 1'b0;
    held_count = 0;

    used = '0;
    for (int i = 0; i < BLK; i++) begin
      have = 1'b0;
      best = 0;
      best_key = '0;
      for (int j = 0; j < BLK; j++) begin
        if (!used[j] && (!have || rank_key(held_samples[j], j) > best_key)) begin
          best_key = rank_key(held_samples[j], j);
          best = j;
          have = 1'b1;
        end
      end
      used[best] = 1'b1;
      order[i] = best;
    end

    for (int k = 0; k < MAX_WORDS; k++) block_bytes[k] = 8'h00;
    block_len = 2;
    bitpos = 0;
    taken = '0;
    perm = '0;
    prev_mag = '0;
    stop = 1'b0;
    for (int i = 0; i < BLK; i++) begin
      p = order[i];
      raw = held_samples[p];
      cnt = 0;
      for (int j = 0; j < p; j++) begin
        if (!taken[j]) cnt++;
      end
      taken[p] = 1'b1;
      if (i < BLK - 1) perm = (perm + cnt) * (BLK - i - 1);
      if (!stop) begin
        if (i == 0) begin
          block_bytes[block_len]     = raw[7:0];
          block_bytes[block_len + 1] = raw[15:8];
          block_len += 2;
        end else begin
          v = {{16{raw[15]}}, raw};
          nb = top_bit(prev_mag) + 2;
          for (int k = nb; k > 0; k--) begin
            if (bitpos == 0) begin
              if (block_len >= MAX_WORDS) break;
              block_bytes[block_len] = 8'h00;
              block_len++;
            end
            if (v[k-1]) block_bytes[block_len-1][7-bitpos] = 1'b1;
            bitpos = (bitpos + 1) % 8;
          end
        end
        prev_mag = magnitude(raw);
        if (prev_mag == 0) stop = 1'b1;
      end
    end
    block_bytes[0] = perm[7:0];
    block_bytes[1] = perm[15:8];
    return 1'b1;
  endfunction

  function automatic logic [15:0] pick_sample(sample_mode_t mode);
    int t;
    int w;
    t = 0;
    case (mode)
      MODE_FULL: begin
        t = $urandom_range(0, 65535);
      end
      MODE_TINY: begin
        t = $urandom_range(0, 16);
        t = t - 8;
      end
      MODE_EXTREME: begin
        case ($urandom_range(0, 6))
          0: t = 32'h8000;
          1: t = 32'h7fff;
          2: t = -1;
          3: t = 1;
          4: t = 0;
          5: t = 32'h8001;
          default: t = $urandom_range(0, 65535);
        endcase
      end
      MODE_WIDTH: begin
        w = $urandom_range(0, 15);
        t = $urandom & ((1 << w) - 1);
        if ($urandom_range(0, 1) == 1) t = -t;
      end
      default: begin
        t = ($urandom_range(0, 1) == 1) ? rep_value : -rep_value;
      end
    endcase
    return t[15:0];
  endfunction

  // one word on the input side; holds tvalid high between back-to-back words
  task automatic send_sample(logic [15:0] s, logic [2:0] n_fixed, logic [31:0] fixed_bytes);
    if (idle_level != 0 && $urandom_range(0, (idle_level == 1) ? 7 : 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (encode_sample(s)) begin
      if (n_fixed != 0) begin
        for (int k = 0; k < n_fixed; k++)
          expected_words.push_back('{fixed_bytes[8*k +: 8], k == n_fixed - 1});
      end else begin
        for (int k = 0; k < block_len; k++)
          expected_words.push_back('{block_bytes[k], k == block_len - 1});
      end
    end
  endtask

  // output side back-pressure
  initial begin
    while (!rst_n) @(posedge clk);
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idle_level != 0 && $urandom_range(0, (idle_level == 1) ? 9 : 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_out
    out_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: code_byte %02h block_end %0b", out_tdata, out_tlast);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (want.code_byte !== out_tdata) begin
          $error("code_byte: expected %02h, got %02h", want.code_byte, out_tdata);
          fail_count++;
        end
        if (want.block_end !== out_tlast) begin
          $error("block_end: expected %0b, got %0b", want.block_end, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any word moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sample_mode_t mode;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    idle_level = 1;
    for (int r = 0; r < DIRECT_LEN; r++)
      send_sample(DIRECTED_ROWS[r].sample, DIRECTED_ROWS[r].n_fixed,
                  DIRECTED_ROWS[r].fixed_bytes);

    for (int b = 0; b < N_BLOCKS; b++) begin
      idle_level = (b >= N_BLOCKS - CALM_TAIL) ? 0 : $urandom_range(0, 2);
      mode = sample_mode_t'($urandom_range(0, 4));
      rep_value = $urandom_range(0, 32768);
      for (int k = 0; k < BLK; k++)
        send_sample(pick_sample(mode), 3'd0, 32'h0);
    end
    in_tvalid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    // catch any stray word after the last block
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sorted_block_sample_packer_unit.f
+incdir+rtl
rtl/sbsp_pkg.sv
rtl/sbsp_rank.sv
rtl/sorted_block_sample_packer_unit.sv
tb/sorted_block_sample_packer_unit_test.sv
